// ----- rtl/core/nta_pkg.sv -----
package nta_pkg;

   localparam int MAX_HELD    = 8;
   localparam int MAX_OCTAVES = 4;
   localparam int MAX_SND     = 32;
   localparam int SORT_DEPTH  = MAX_HELD * MAX_OCTAVES;

   localparam int HELD_IW = $clog2(MAX_HELD);
   localparam int HELD_CW = $clog2(MAX_HELD + 1);
   localparam int SND_IW  = $clog2(MAX_SND);
   localparam int SND_CW  = $clog2(MAX_SND + 1);
   localparam int SORT_IW = $clog2(SORT_DEPTH);
   localparam int SORT_CW = $clog2(SORT_DEPTH + 1);

   // Widths of the shared remainder unit.
   localparam int DIV_NW = 33;
   localparam int DIV_DW = 32;

   // Input operations.
   localparam logic [2:0] OP_NOTE_ON  = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF = 3'd1;
   localparam logic [2:0] OP_SUSTAIN  = 3'd2;
   localparam logic [2:0] OP_ALL_OFF  = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_ON      = 2'd0;
   localparam logic [1:0] KIND_OFF     = 2'd1;
   localparam logic [1:0] KIND_SUSTAIN = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_OCTAVES = 3'd1;
   localparam logic [2:0] REG_PULSES  = 3'd2;
   localparam logic [2:0] REG_STEPS   = 3'd3;
   localparam logic [2:0] REG_PERIOD  = 3'd4;
   localparam logic [2:0] REG_GATE    = 3'd5;
   localparam logic [2:0] REG_CHANCE  = 3'd6;

   // Pick modes.
   localparam logic [2:0] PICK_UP       = 3'd0;
   localparam logic [2:0] PICK_DOWN     = 3'd1;
   localparam logic [2:0] PICK_UPDOWN   = 3'd2;
   localparam logic [2:0] PICK_CONVERGE = 3'd3;
   localparam logic [2:0] PICK_DIVERGE  = 3'd4;
   localparam logic [2:0] PICK_RANDOM   = 3'd5;
   localparam logic [2:0] PICK_WALK     = 3'd6;
   localparam logic [2:0] PICK_CHORD    = 3'd7;

   localparam logic [6:0] SUSTAIN_CC   = 7'd64;
   localparam logic [6:0] PEDAL_LEVEL  = 7'd64;
   localparam logic [6:0] NOTE_MAX     = 7'd127;
   localparam logic [7:0] OCTAVE_STEP  = 8'd12;
   localparam logic [31:0] MIN_PERIOD  = 32'd256;

   typedef struct packed {
      logic [4:0] ch;
      logic [6:0] nn;
      logic [6:0] vel;
   } key_type;

   typedef struct packed {
      logic [4:0]  ch;
      logic [6:0]  nn;
      logic [23:0] remain;
   } voice_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] ch;
      logic [6:0] note;
      logic [6:0] val;
   } event_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_ON_POOL,
      S_FILT,
      S_SUS_EMIT,
      S_SIL,
      S_AGE,
      S_SORT,
      S_SPREAD,
      S_PHASE,
      S_PHASE_W,
      S_EUC,
      S_EUC_W1,
      S_EUC_W2,
      S_SKIP,
      S_PICK_W,
      S_MUT,
      S_EMIT,
      S_FIN
   } state_type;

endpackage

// ----- rtl/core/nta_div.sv -----
module nta_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [nta_pkg::DIV_NW-1:0]   dividend,
   input  logic [nta_pkg::DIV_DW-1:0]   divisor,
   output logic                         done,
   output logic [nta_pkg::DIV_DW-1:0]   remainder
);
   import nta_pkg::*;

   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_NW-1:0] num_ff, num_in;
   logic [DIV_DW-1:0] dvs_ff, dvs_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW:0]   shifted;
   logic [DIV_DW+1:0] trial;

   // One remainder bit per cycle, restoring form.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, num_ff[DIV_NW-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NW);
         num_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial[DIV_DW+1]) begin
            rem_in = shifted[DIV_DW-1:0];
         end else begin
            rem_in = trial[DIV_DW-1:0];
         end
         num_in = {num_ff[DIV_NW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/nta_emit.sv -----
module nta_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  nta_pkg::event_type  push_data,
   input  logic                flush,
   output logic                push_ok,
   output logic                pend_empty,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,  // out_channel, out_note, out_value, zero pad
   output logic [1:0]          rsp_tuser,  // kind
   output logic                rsp_tlast
);
   import nta_pkg::*;

   logic      out_valid_ff, out_valid_in;
   logic      out_last_ff, out_last_in;
   event_type out_ev_ff, out_ev_in;
   logic      pend_valid_ff, pend_valid_in;
   event_type pend_ev_ff, pend_ev_in;
   logic      out_free;

   // The newest event waits one place back so that the final one can be marked.
   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      push_ok       = !pend_valid_ff || out_free;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_last_in   = out_last_ff;
      out_ev_in     = out_ev_ff;
      pend_valid_in = pend_valid_ff;
      pend_ev_in    = pend_ev_ff;
      if (push_valid && push_ok) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_ev_in    = pend_ev_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_ev_in    = push_data;
      end else if (flush && pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_ev_in     = pend_ev_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_last_ff <= out_last_in;
      out_ev_ff   <= out_ev_in;
      pend_ev_ff  <= pend_ev_in;
   end

   assign pend_empty = !pend_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_ev_ff.val, out_ev_ff.note, out_ev_ff.ch};
   assign rsp_tuser  = out_ev_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- rtl/core/note_arpeggiator.sv -----
// Arpeggiator with Euclidean gating. Items enter on the req_ channel: note on, note
// off, sustain controller, all notes off and one sample tick each. Results leave on the
// rsp_ channel as note on, note off and forwarded sustain events; tlast marks the final
// result that one item causes, and an item may cause none.
// Configuration is written through csr_, by the user only while the block is idle;
// the block itself does not enforce this. One item is worked on at a time and
// req_tready is high only between items. A pedal release adds a filtering pass over
// the pool. A tick ages the sounding notes, sorts the pool, spreads it over the
// octaves and, on a step boundary, uses the shared remainder unit once for the step
// phase, up to twice for the Euclidean gate and once for the pick index in the modes
// that need one, before it emits its note ons.
// A stalled rsp_tready holds the block in place without losing anything, while the
// last result waits in the output register and the next item is already taken. Reset
// clears all note lists, the phase, the step count, the walk position and the pedal,
// and loads the register defaults; no clearing pass.
module note_arpeggiator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // channel, note, value, transport_playing, rand_skip, rand_mutate, rand_index,
   // rand_walk, rand_offset, zero pad
   input  logic [63:0] req_tdata,
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_channel, out_note, out_value, zero pad
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import nta_pkg::*;

   // Configuration.
   logic [4:0]  mode_ff;
   logic [2:0]  oct_cnt_ff;
   logic [4:0]  pulses_ff;
   logic [4:0]  steps_ff;
   logic [31:0] period_ff;
   logic [23:0] gate_ff;
   logic [31:0] chance_ff;

   // Item being worked on.
   logic [2:0]  it_op_ff;
   logic [4:0]  it_ch_ff;
   logic [6:0]  it_nn_ff;
   logic [6:0]  it_val_ff;
   logic        it_tp_ff;
   logic [15:0] it_rskip_ff;
   logic [15:0] it_rmut_ff;
   logic [5:0]  it_ridx_ff;
   logic [1:0]  it_rwalk_ff;
   logic [2:0]  it_roff_ff;

   state_type state_ff, state_in;

   key_type     held_ff [MAX_HELD];
   key_type     held_in [MAX_HELD];
   logic [HELD_CW-1:0] held_n_ff, held_n_in;
   key_type     pool_ff [MAX_HELD];
   key_type     pool_in [MAX_HELD];
   logic [HELD_CW-1:0] pool_n_ff, pool_n_in;
   logic [6:0]  base_ff [MAX_HELD];
   logic [6:0]  base_in [MAX_HELD];
   logic [6:0]  sorted_ff [SORT_DEPTH];
   logic [6:0]  sorted_in [SORT_DEPTH];
   logic [SORT_CW-1:0] p_ff, p_in;
   voice_type   snd_ff [MAX_SND];
   voice_type   snd_in [MAX_SND];
   logic [SND_CW-1:0] snd_n_ff, snd_n_in;

   logic [31:0] phase_ff, phase_in;
   logic [31:0] step_ff, step_in;
   logic [5:0]  walk_ff, walk_in;
   logic        pedal_ff, pedal_in;

   logic [SORT_CW-1:0] i_ff, i_in;
   logic [SORT_CW-1:0] w_ff, w_in;
   logic [SORT_CW-1:0] stop_ff, stop_in;
   logic [SORT_CW-1:0] idx_ff, idx_in;
   logic [1:0]  oct_ff, oct_in;
   logic [4:0]  dch_ff, dch_in;
   logic [6:0]  dvel_ff, dvel_in;

   // Lookups in the key lists.
   logic               held_hit, pool_hit, filt_hit;
   logic [HELD_IW-1:0] held_pos, pool_pos;
   key_type            filt_key;

   // Emitter and remainder unit.
   logic        push_valid, push_ok, flush, pend_empty;
   event_type   push_data;
   logic        div_start, div_done;
   logic [DIV_NW-1:0] div_num;
   logic [DIV_DW-1:0] div_dvs;
   logic [DIV_DW-1:0] div_rem;

   always_comb begin
      held_hit = 1'b0;
      held_pos = '0;
      pool_hit = 1'b0;
      pool_pos = '0;
      filt_hit = 1'b0;
      filt_key = pool_ff[i_ff[HELD_IW-1:0]];
      for (int j = 0; j < MAX_HELD; j++) begin
         if (HELD_CW'(j) < held_n_ff && held_ff[j].ch == it_ch_ff
             && held_ff[j].nn == it_nn_ff) begin
            held_hit = 1'b1;
            held_pos = HELD_IW'(j);
         end
         if (HELD_CW'(j) < pool_n_ff && pool_ff[j].ch == it_ch_ff
             && pool_ff[j].nn == it_nn_ff) begin
            pool_hit = 1'b1;
            pool_pos = HELD_IW'(j);
         end
         if (HELD_CW'(j) < held_n_ff && held_ff[j].ch == filt_key.ch
             && held_ff[j].nn == filt_key.nn) begin
            filt_hit = 1'b1;
         end
      end
   end

   always_comb begin
      logic               is_on, is_off, hold, need_tp, down;
      logic [2:0]         oct_lim;
      logic [HELD_IW-1:0] ins_pos;
      logic [6:0]         ins_v;
      logic [7:0]         spread_v;
      logic [31:0]        per;
      logic [32:0]        sum;
      logic [9:0]         euc_prod;
      logic [15:0]        skip_thr, mut_thr;
      logic [2:0]         pick;
      logic [SORT_CW-1:0] pm1;
      logic [SORT_CW:0]   cyc;
      logic [SORT_CW-1:0] half_p1;
      logic [SORT_CW-1:0] center;
      logic [SORT_CW:0]   r;
      logic [SORT_CW:0]   t;
      logic [SORT_CW-1:0] wpos;
      logic [2:0]         offc;
      logic signed [SORT_CW+1:0] mt;
      voice_type          ve;

      state_in  = state_ff;
      held_in   = held_ff;
      held_n_in = held_n_ff;
      pool_in   = pool_ff;
      pool_n_in = pool_n_ff;
      base_in   = base_ff;
      sorted_in = sorted_ff;
      p_in      = p_ff;
      snd_in    = snd_ff;
      snd_n_in  = snd_n_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      walk_in   = walk_ff;
      pedal_in  = pedal_ff;
      i_in      = i_ff;
      w_in      = w_ff;
      stop_in   = stop_ff;
      idx_in    = idx_ff;
      oct_in    = oct_ff;
      dch_in    = dch_ff;
      dvel_in   = dvel_ff;

      push_valid = 1'b0;
      push_data  = '0;
      flush      = 1'b0;
      div_start  = 1'b0;
      div_num    = '0;
      div_dvs    = '0;
      req_tready = 1'b0;

      is_on   = (it_op_ff == OP_NOTE_ON) && (it_val_ff != 7'd0);
      is_off  = (it_op_ff == OP_NOTE_OFF) || ((it_op_ff == OP_NOTE_ON) && (it_val_ff == 7'd0));
      hold    = mode_ff[3];
      need_tp = mode_ff[4];
      down    = it_val_ff >= PEDAL_LEVEL;
      if (oct_cnt_ff == 3'd0) begin
         oct_lim = 3'd1;
      end else if (oct_cnt_ff > 3'(MAX_OCTAVES)) begin
         oct_lim = 3'(MAX_OCTAVES);
      end else begin
         oct_lim = oct_cnt_ff;
      end

      // Insertion point: after every earlier note that is not higher.
      ins_v   = pool_ff[i_ff[HELD_IW-1:0]].nn;
      ins_pos = '0;
      for (int j = 0; j < MAX_HELD; j++) begin
         if (SORT_CW'(j) < i_ff && base_ff[j] <= ins_v) begin
            ins_pos = ins_pos + 1'b1;
         end
      end
      spread_v = {1'b0, base_ff[i_ff[HELD_IW-1:0]]} + 8'(oct_ff) * OCTAVE_STEP;

      per      = (period_ff < MIN_PERIOD) ? MIN_PERIOD : period_ff;
      sum      = {1'b0, phase_ff} + 33'(MIN_PERIOD);
      euc_prod = div_rem[4:0] * pulses_ff;
      skip_thr = chance_ff[15:0];
      mut_thr  = chance_ff[31:16];
      pick     = mode_ff[2:0];
      pm1      = p_ff - 1'b1;
      cyc      = (p_ff > SORT_CW'(1)) ? ({1'b0, p_ff} << 1) - 2'd2 : (SORT_CW+1)'(1);
      half_p1  = (p_ff >> 1) + 1'b1;
      center   = p_ff >> 1;
      r        = div_rem[SORT_CW:0];
      t        = '0;
      wpos     = (SORT_CW'(walk_ff) > pm1) ? pm1 : SORT_CW'(walk_ff);
      offc     = (it_roff_ff > 3'd4) ? 3'd4 : it_roff_ff;
      mt       = $signed({2'b00, idx_ff}) + $signed((SORT_CW+2)'(offc))
                 - $signed((SORT_CW+2)'(2));
      ve       = snd_ff[i_ff[SND_IW-1:0]];

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            if (is_on) begin
               if (held_hit) begin
                  held_in[held_pos].vel = it_val_ff;
               end else begin
                  if (hold && held_n_ff == '0) begin
                     pool_n_in = '0;
                  end
                  if (held_n_ff < HELD_CW'(MAX_HELD)) begin
                     held_in[held_n_ff[HELD_IW-1:0]] = '{ch: it_ch_ff, nn: it_nn_ff,
                                                         vel: it_val_ff};
                     held_n_in = held_n_ff + 1'b1;
                  end
               end
               state_in = S_ON_POOL;
            end else if (is_off) begin
               // Entries are unique, so removal closes one gap.
               if (held_hit) begin
                  for (int j = 0; j < MAX_HELD - 1; j++) begin
                     if (HELD_IW'(j) >= held_pos) begin
                        held_in[j] = held_ff[j+1];
                     end
                  end
                  held_n_in = held_n_ff - 1'b1;
               end
               if (pool_hit && !hold && !pedal_ff) begin
                  for (int j = 0; j < MAX_HELD - 1; j++) begin
                     if (HELD_IW'(j) >= pool_pos) begin
                        pool_in[j] = pool_ff[j+1];
                     end
                  end
                  pool_n_in = pool_n_ff - 1'b1;
               end
               state_in = S_FIN;
            end else if (it_op_ff == OP_SUSTAIN) begin
               pedal_in = down;
               i_in     = '0;
               w_in     = '0;
               if (pedal_ff && !down && !hold) begin
                  state_in = S_FILT;
               end else begin
                  state_in = S_SUS_EMIT;
               end
            end else if (it_op_ff == OP_ALL_OFF) begin
               held_n_in = '0;
               pool_n_in = '0;
               pedal_in  = 1'b0;
               i_in      = '0;
               state_in  = S_SIL;
            end else if (it_op_ff == OP_TICK) begin
               i_in = '0;
               w_in = '0;
               if (need_tp && !it_tp_ff) begin
                  state_in = S_SIL;
               end else if (pool_n_ff == '0) begin
                  phase_in = '0;
                  step_in  = '0;
                  state_in = S_SIL;
               end else begin
                  dch_in   = pool_ff[0].ch;
                  dvel_in  = pool_ff[0].vel;
                  state_in = S_AGE;
               end
            end else begin
               state_in = S_FIN;
            end
         end

         S_ON_POOL: begin
            if (pool_hit) begin
               pool_in[pool_pos].vel = it_val_ff;
            end else if (pool_n_ff < HELD_CW'(MAX_HELD)) begin
               pool_in[pool_n_ff[HELD_IW-1:0]] = '{ch: it_ch_ff, nn: it_nn_ff,
                                                   vel: it_val_ff};
               pool_n_in = pool_n_ff + 1'b1;
            end
            state_in = S_FIN;
         end

         S_FILT: begin
            // Pedal release keeps only the pool entries whose key is still down.
            if (i_ff < SORT_CW'(pool_n_ff)) begin
               if (filt_hit) begin
                  pool_in[w_ff[HELD_IW-1:0]] = filt_key;
                  w_in = w_ff + 1'b1;
               end
               i_in = i_ff + 1'b1;
            end else begin
               pool_n_in = w_ff[HELD_CW-1:0];
               state_in  = S_SUS_EMIT;
            end
         end

         S_SUS_EMIT: begin
            push_valid = push_ok;
            push_data  = '{kind: KIND_SUSTAIN, ch: it_ch_ff, note: SUSTAIN_CC,
                           val: it_val_ff};
            if (push_ok) begin
               state_in = S_FIN;
            end
         end

         S_SIL: begin
            if (i_ff < SORT_CW'(snd_n_ff)) begin
               push_valid = push_ok;
               push_data  = '{kind: KIND_OFF, ch: ve.ch, note: ve.nn, val: 7'd0};
               if (push_ok) begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               snd_n_in = '0;
               state_in = S_FIN;
            end
         end

         S_AGE: begin
            if (i_ff < SORT_CW'(snd_n_ff)) begin
               if (ve.remain <= 24'd1) begin
                  push_valid = push_ok;
                  push_data  = '{kind: KIND_OFF, ch: ve.ch, note: ve.nn, val: 7'd0};
                  if (push_ok) begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  snd_in[w_ff[SND_IW-1:0]] = '{ch: ve.ch, nn: ve.nn,
                                              remain: ve.remain - 24'd1};
                  w_in = w_ff + 1'b1;
                  i_in = i_ff + 1'b1;
               end
            end else begin
               snd_n_in = w_ff[SND_CW-1:0];
               i_in     = '0;
               state_in = S_SORT;
            end
         end

         S_SORT: begin
            if (i_ff < SORT_CW'(pool_n_ff)) begin
               for (int j = 0; j < MAX_HELD; j++) begin
                  if (HELD_IW'(j) == ins_pos) begin
                     base_in[j] = ins_v;
                  end else if (j > 0 && HELD_IW'(j) > ins_pos) begin
                     base_in[j] = base_ff[j-1];
                  end
               end
               i_in = i_ff + 1'b1;
            end else begin
               i_in     = '0;
               oct_in   = '0;
               p_in     = '0;
               state_in = S_SPREAD;
            end
         end

         S_SPREAD: begin
            if (spread_v <= {1'b0, NOTE_MAX} && p_ff < SORT_CW'(SORT_DEPTH)) begin
               sorted_in[p_ff[SORT_IW-1:0]] = spread_v[6:0];
               p_in = p_ff + 1'b1;
            end
            if (i_ff + 1'b1 == SORT_CW'(pool_n_ff)) begin
               i_in = '0;
               if (3'(oct_ff) + 3'd1 == oct_lim) begin
                  state_in = S_PHASE;
               end else begin
                  oct_in = oct_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end

         S_PHASE: begin
            if (p_ff == '0) begin
               state_in = S_FIN;
            end else if (sum < {1'b0, per}) begin
               phase_in = sum[31:0];
               state_in = S_FIN;
            end else begin
               div_start = 1'b1;
               div_num   = sum - {1'b0, per};
               div_dvs   = per;
               state_in  = S_PHASE_W;
            end
         end

         S_PHASE_W: begin
            if (div_done) begin
               phase_in = div_rem;
               step_in  = step_ff + 32'd1;
               state_in = S_EUC;
            end
         end

         S_EUC: begin
            if (pulses_ff >= steps_ff) begin
               state_in = S_SKIP;
            end else if (pulses_ff == 5'd0) begin
               state_in = S_FIN;
            end else begin
               div_start = 1'b1;
               div_num   = {1'b0, step_ff};
               div_dvs   = 32'(steps_ff);
               state_in  = S_EUC_W1;
            end
         end

         S_EUC_W1: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = DIV_NW'(euc_prod);
               div_dvs   = 32'(steps_ff);
               state_in  = S_EUC_W2;
            end
         end

         S_EUC_W2: begin
            if (div_done) begin
               if (div_rem < 32'(pulses_ff)) begin
                  state_in = S_SKIP;
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         S_SKIP: begin
            if (skip_thr != 16'd0 && it_rskip_ff < skip_thr) begin
               state_in = S_FIN;
            end else begin
               case (pick)
                  PICK_CHORD: begin
                     i_in     = '0;
                     stop_in  = p_ff;
                     state_in = S_EMIT;
                  end
                  PICK_UP, PICK_DOWN: begin
                     div_start = 1'b1;
                     div_num   = {1'b0, step_ff};
                     div_dvs   = 32'(p_ff);
                     state_in  = S_PICK_W;
                  end
                  PICK_UPDOWN: begin
                     div_start = 1'b1;
                     div_num   = {1'b0, step_ff};
                     div_dvs   = 32'(cyc);
                     state_in  = S_PICK_W;
                  end
                  PICK_CONVERGE: begin
                     div_start = 1'b1;
                     div_num   = {2'b00, step_ff[31:1]};
                     div_dvs   = 32'(p_ff);
                     state_in  = S_PICK_W;
                  end
                  PICK_DIVERGE: begin
                     div_start = 1'b1;
                     div_num   = {2'b00, step_ff[31:1]};
                     div_dvs   = 32'(half_p1);
                     state_in  = S_PICK_W;
                  end
                  PICK_RANDOM: begin
                     idx_in   = (SORT_CW'(it_ridx_ff) > pm1) ? pm1 : SORT_CW'(it_ridx_ff);
                     state_in = S_MUT;
                  end
                  default: begin
                     // Walk: step down, stay or step up inside the pool.
                     if (it_rwalk_ff == 2'd0) begin
                        idx_in = (wpos == '0) ? '0 : wpos - 1'b1;
                     end else if (it_rwalk_ff == 2'd1) begin
                        idx_in = wpos;
                     end else begin
                        idx_in = (wpos == pm1) ? pm1 : wpos + 1'b1;
                     end
                     walk_in  = 6'(idx_in);
                     state_in = S_MUT;
                  end
               endcase
            end
         end

         S_PICK_W: begin
            if (div_done) begin
               case (pick)
                  PICK_UP: t = r;
                  PICK_DOWN: t = {1'b0, pm1} - r;
                  PICK_UPDOWN: t = (r < {1'b0, p_ff}) ? r : cyc - r;
                  PICK_CONVERGE: t = step_ff[0] ? {1'b0, pm1} - r : r;
                  default: begin
                     if (step_ff[0]) begin
                        t = {1'b0, center} - r;
                     end else begin
                        t = {1'b0, center} + r;
                        if (t > {1'b0, pm1}) begin
                           t = {1'b0, pm1};
                        end
                     end
                  end
               endcase
               idx_in   = t[SORT_CW-1:0];
               state_in = S_MUT;
            end
         end

         S_MUT: begin
            if (mut_thr != 16'd0 && it_rmut_ff < mut_thr) begin
               if (mt < 0) begin
                  idx_in = '0;
               end else if (mt > $signed({2'b00, pm1})) begin
                  idx_in = pm1;
               end else begin
                  idx_in = mt[SORT_CW-1:0];
               end
               i_in    = idx_in;
               stop_in = idx_in + 1'b1;
            end else begin
               i_in    = idx_ff;
               stop_in = idx_ff + 1'b1;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (i_ff < stop_ff) begin
               push_valid = push_ok;
               push_data  = '{kind: KIND_ON, ch: dch_ff,
                              note: sorted_ff[i_ff[SORT_IW-1:0]], val: dvel_ff};
               if (push_ok) begin
                  if (snd_n_ff < SND_CW'(MAX_SND)) begin
                     snd_in[snd_n_ff[SND_IW-1:0]] = '{ch: dch_ff,
                                                      nn: sorted_ff[i_ff[SORT_IW-1:0]],
                                                      remain: gate_ff};
                     snd_n_in = snd_n_ff + 1'b1;
                  end
                  i_in = i_ff + 1'b1;
               end
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            flush = 1'b1;
            if (pend_empty) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         held_n_ff  <= '0;
         pool_n_ff  <= '0;
         snd_n_ff   <= '0;
         phase_ff   <= '0;
         step_ff    <= '0;
         walk_ff    <= '0;
         pedal_ff   <= 1'b0;
         mode_ff    <= 5'd0;
         oct_cnt_ff <= 3'd1;
         pulses_ff  <= 5'd16;
         steps_ff   <= 5'd16;
         period_ff  <= 32'd3072;
         gate_ff    <= 24'd9;
         chance_ff  <= 32'd0;
      end else begin
         state_ff  <= state_in;
         held_n_ff <= held_n_in;
         pool_n_ff <= pool_n_in;
         snd_n_ff  <= snd_n_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         walk_ff   <= walk_in;
         pedal_ff  <= pedal_in;
         if (csr_wr_en) begin
            unique case (csr_addr)
               REG_MODE:    mode_ff    <= csr_wdata[4:0];
               REG_OCTAVES: oct_cnt_ff <= csr_wdata[2:0];
               REG_PULSES:  pulses_ff  <= csr_wdata[4:0];
               REG_STEPS:   steps_ff   <= csr_wdata[4:0];
               REG_PERIOD:  period_ff  <= csr_wdata;
               REG_GATE:    gate_ff    <= csr_wdata[23:0];
               REG_CHANCE:  chance_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff   <= held_in;
      pool_ff   <= pool_in;
      base_ff   <= base_in;
      sorted_ff <= sorted_in;
      snd_ff    <= snd_in;
      p_ff      <= p_in;
      i_ff      <= i_in;
      w_ff      <= w_in;
      stop_ff   <= stop_in;
      idx_ff    <= idx_in;
      oct_ff    <= oct_in;
      dch_ff    <= dch_in;
      dvel_ff   <= dvel_in;
      if (req_tvalid && req_tready) begin
         it_op_ff    <= req_tuser;
         it_ch_ff    <= req_tdata[4:0];
         it_nn_ff    <= req_tdata[11:5];
         it_val_ff   <= req_tdata[18:12];
         it_tp_ff    <= req_tdata[19];
         it_rskip_ff <= req_tdata[35:20];
         it_rmut_ff  <= req_tdata[51:36];
         it_ridx_ff  <= req_tdata[57:52];
         it_rwalk_ff <= req_tdata[59:58];
         it_roff_ff  <= req_tdata[62:60];
      end
   end

   nta_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_dvs),
      .done      (div_done),
      .remainder (div_rem)
   );

   nta_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .flush      (flush),
      .push_ok    (push_ok),
      .pend_empty (pend_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- bench/tb_note_arpeggiator.sv -----
import nta_pkg::*;

typedef struct {
   logic [2:0]  op;
   logic [4:0]  ch;
   logic [6:0]  nn;
   logic [6:0]  val;
   bit          tp;
   logic [15:0] rs;
   logic [15:0] rm;
   logic [5:0]  ri;
   logic [1:0]  rw;
   logic [2:0]  ro;
} arp_item_type;

typedef struct {
   logic [1:0] kind;
   logic [4:0] ch;
   logic [6:0] nn;
   logic [6:0] val;
   bit         last;
} arp_event_type;

class arp_scoreboard;
   logic [4:0]  mode_flags = 0;
   logic [2:0]  octave_count = 1;
   logic [4:0]  euclid_pulses = 16;
   logic [4:0]  euclid_steps = 16;
   logic [31:0] step_period = 3072;
   logic [23:0] gate_samples = 9;
   logic [31:0] chance_thresholds = 0;

   key_type     held[MAX_HELD];
   int          held_n = 0;
   key_type     pool[MAX_HELD];
   int          pool_n = 0;
   logic [6:0]  sorted[SORT_DEPTH];
   voice_type   voices[MAX_SND];
   int          voice_n = 0;
   logic [31:0] phase = 0;
   logic [31:0] step_count = 0;
   int          walk_pos = 0;
   bit          pedal = 0;

   arp_event_type cur[$];
   arp_event_type expected_events[$];
   int            errors = 0;

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function void emit(logic [1:0] k, logic [4:0] c, logic [6:0] n, logic [6:0] v);
      arp_event_type e;
      if (cur.size() < 64) begin
         e.kind = k; e.ch = c; e.nn = n; e.val = v; e.last = 0;
         cur = {cur, e};
      end
   endfunction

   function int find_key(bit in_pool, logic [4:0] c, logic [6:0] n);
      int cnt;
      key_type k;
      cnt = in_pool ? pool_n : held_n;
      for (int i = 0; i < cnt; i++) begin
         k = in_pool ? pool[i] : held[i];
         if (k.ch == c && k.nn == n) return i;
      end
      return -1;
   endfunction

   function void remove_key(bit in_pool, logic [4:0] c, logic [6:0] n);
      int w;
      w = 0;
      if (in_pool) begin
         for (int i = 0; i < pool_n; i++)
            if (!(pool[i].ch == c && pool[i].nn == n)) begin
               pool[w] = pool[i]; w++;
            end
         pool_n = w;
      end else begin
         for (int i = 0; i < held_n; i++)
            if (!(held[i].ch == c && held[i].nn == n)) begin
               held[w] = held[i]; w++;
            end
         held_n = w;
      end
   endfunction

   function void silence();
      for (int i = 0; i < voice_n; i++) emit(KIND_OFF, voices[i].ch, voices[i].nn, 0);
      voice_n = 0;
   endfunction

   function int build_sorted();
      logic [6:0] base[MAX_HELD];
      logic [6:0] v;
      int j, cnt, octs, s;
      cnt = 0;
      for (int i = 0; i < pool_n; i++) begin
         v = pool[i].nn;
         j = i;
         while (j > 0 && base[j-1] > v) begin
            base[j] = base[j-1]; j--;
         end
         base[j] = v;
      end
      octs = clampi(int'(octave_count), 1, MAX_OCTAVES);
      for (int o = 0; o < octs; o++)
         for (int i = 0; i < pool_n; i++) begin
            s = int'(base[i]) + o * 12;
            if (s <= 127 && cnt < SORT_DEPTH) begin
               sorted[cnt] = s[6:0]; cnt++;
            end
         end
      return cnt;
   endfunction

   function bit euclid_hit();
      longint p, s;
      p = euclid_pulses;
      s = euclid_steps;
      if (p >= s) return 1;
      if (p == 0) return 0;
      return (((longint'(step_count) % s) * p) % s) < p;
   endfunction

   function int pick_index(int np, logic [2:0] mode, arp_item_type it);
      longint c, up, cyc, pos;
      int half, center, off, stp, w;
      c = step_count;
      up = np;
      case (mode)
         PICK_UP: return int'(c % up);
         PICK_DOWN: return np - 1 - int'(c % up);
         PICK_UPDOWN: begin
            cyc = np > 1 ? 2 * up - 2 : 1;
            pos = c % cyc;
            return pos < up ? int'(pos) : int'(cyc - pos);
         end
         PICK_CONVERGE: begin
            half = int'((c / 2) % up);
            return (c % 2 == 0) ? half : np - 1 - half;
         end
         PICK_DIVERGE: begin
            center = np / 2;
            off = int'((c / 2) % (np / 2 + 1));
            return clampi((c % 2 == 0) ? center + off : center - off, 0, np - 1);
         end
         PICK_RANDOM: return clampi(int'(it.ri), 0, np - 1);
         default: begin
            stp = (it.rw > 2 ? 2 : int'(it.rw)) - 1;
            w = clampi(walk_pos, 0, np - 1);
            walk_pos = clampi(w + stp, 0, np - 1);
            return walk_pos;
         end
      endcase
   endfunction

   function void tick(arp_item_type it);
      logic [4:0] dch;
      logic [6:0] dvel;
      logic [2:0] mode;
      int w, np, idx, off, first, count;
      longint per, sum;
      if (mode_flags[4] && !it.tp) begin
         silence();
         return;
      end
      if (pool_n == 0) begin
         silence(); phase = 0; step_count = 0;
         return;
      end
      dch = pool[0].ch;
      dvel = pool[0].vel;
      w = 0;
      for (int i = 0; i < voice_n; i++) begin
         if (voices[i].remain <= 1) emit(KIND_OFF, voices[i].ch, voices[i].nn, 0);
         else begin
            voices[i].remain--; voices[w] = voices[i]; w++;
         end
      end
      voice_n = w;
      np = build_sorted();
      if (np == 0) return;
      per = step_period < 256 ? 256 : step_period;
      sum = longint'(phase) + 256;
      if (sum < per) begin
         phase = sum[31:0];
         return;
      end
      sum = (sum - per) % per;
      phase = sum[31:0];
      step_count++;
      if (!euclid_hit()) return;
      if (chance_thresholds[15:0] != 0 && it.rs < chance_thresholds[15:0]) return;
      mode = mode_flags[2:0];
      first = 0;
      count = np;
      if (mode != PICK_CHORD) begin
         idx = pick_index(np, mode, it);
         if (chance_thresholds[31:16] != 0 && it.rm < chance_thresholds[31:16]) begin
            off = (it.ro > 4 ? 4 : int'(it.ro)) - 2;
            idx = clampi(idx + off, 0, np - 1);
         end
         first = clampi(idx, 0, np - 1);
         count = 1;
      end
      for (int i = first; i < first + count; i++) begin
         emit(KIND_ON, dch, sorted[i], dvel);
         if (voice_n < MAX_SND) begin
            voices[voice_n].ch = dch;
            voices[voice_n].nn = sorted[i];
            voices[voice_n].remain = gate_samples;
            voice_n++;
         end
      end
   endfunction

   // Works out the events caused by one accepted item and queues them.
   function void note_item(arp_item_type it);
      logic [2:0] op;
      bit hold;
      int i, w;
      op = it.op;
      hold = mode_flags[3];
      cur.delete();
      if (op == OP_NOTE_ON && it.val == 0) op = OP_NOTE_OFF;
      case (op)
         OP_NOTE_ON: begin
            i = find_key(0, it.ch, it.nn);
            if (i < 0) begin
               if (hold && held_n == 0) pool_n = 0;
               if (held_n < MAX_HELD) begin
                  held[held_n] = '{it.ch, it.nn, it.val}; held_n++;
               end
            end else held[i].vel = it.val;
            i = find_key(1, it.ch, it.nn);
            if (i < 0) begin
               if (pool_n < MAX_HELD) begin
                  pool[pool_n] = '{it.ch, it.nn, it.val}; pool_n++;
               end
            end else pool[i].vel = it.val;
         end
         OP_NOTE_OFF: begin
            remove_key(0, it.ch, it.nn);
            if (!hold && !pedal) remove_key(1, it.ch, it.nn);
         end
         OP_SUSTAIN: begin
            if (pedal && it.val < PEDAL_LEVEL && !hold) begin
               w = 0;
               for (int j = 0; j < pool_n; j++)
                  if (find_key(0, pool[j].ch, pool[j].nn) >= 0) begin
                     pool[w] = pool[j]; w++;
                  end
               pool_n = w;
            end
            pedal = it.val >= PEDAL_LEVEL;
            emit(KIND_SUSTAIN, it.ch, SUSTAIN_CC, it.val);
         end
         OP_ALL_OFF: begin
            silence();
            held_n = 0; pool_n = 0; pedal = 0;
         end
         OP_TICK: tick(it);
         default: ;
      endcase
      if (cur.size() > 0) cur[cur.size()-1].last = 1;
      expected_events = {expected_events, cur};
   endfunction

   task check(logic [1:0] kind, logic [23:0] data, bit last);
      arp_event_type e;
      if (expected_events.size() == 0) begin
         report($sformatf("event kind %0d note %0d with nothing expected", kind, data[11:5]));
         return;
      end
      e = expected_events.pop_front();
      if (kind !== e.kind) report($sformatf("kind %0d, expected %0d", kind, e.kind));
      if (data[4:0] !== e.ch) report($sformatf("channel %0d, expected %0d", data[4:0], e.ch));
      if (data[11:5] !== e.nn) report($sformatf("note %0d, expected %0d", data[11:5], e.nn));
      if (data[18:12] !== e.val)
         report($sformatf("value %0d, expected %0d", data[18:12], e.val));
      if (data[23:19] !== 0) report("nonzero pad bits in event data");
      if (last !== e.last) report($sformatf("last %0d, expected %0d", last, e.last));
   endtask
endclass

module tb_note_arpeggiator;
   localparam int SETTLE = 400;
   localparam int STALL_LIMIT = 6000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   arp_scoreboard sb = new();
   bit quiet = 0;
   bit long_hold_req = 0;
   int idle_cycles = 0;

   note_arpeggiator uut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic send(arp_item_type it);
      req_tvalid <= 1;
      req_tuser <= it.op;
      req_tdata <= {1'b0, it.ro, it.rw, it.ri, it.rm, it.rs, it.tp, it.val, it.nn, it.ch};
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (sb.expected_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_regs(logic [4:0] mode, logic [2:0] oct, logic [4:0] pulses,
                             logic [4:0] steps, logic [31:0] period, logic [23:0] gate,
                             logic [31:0] chance);
      logic [31:0] vals[7];
      vals = '{32'(mode), 32'(oct), 32'(pulses), 32'(steps), period, 32'(gate), chance};
      for (int r = REG_MODE; r <= REG_CHANCE; r++) begin
         csr_wr_en <= 1;
         csr_addr <= r[2:0];
         csr_wdata <= vals[r];
         @(posedge clock);
      end
      csr_wr_en <= 0;
      sb.mode_flags = mode; sb.octave_count = oct; sb.euclid_pulses = pulses;
      sb.euclid_steps = steps; sb.step_period = period; sb.gate_samples = gate;
      sb.chance_thresholds = chance;
   endtask

   function automatic arp_item_type make_item(logic [2:0] op, logic [4:0] ch, logic [6:0] nn,
                                              logic [6:0] val);
      arp_item_type it;
      it.op = op; it.ch = ch; it.nn = nn; it.val = val;
      it.tp = $urandom_range(0, 6) != 0;
      it.rs = $urandom; it.rm = $urandom;
      it.ri = $urandom_range(0, 63); it.rw = $urandom_range(0, 3);
      it.ro = $urandom_range(0, 7);
      return it;
   endfunction

   // Note traffic stays on a small set of keys so that ons and offs meet and the pool fills.
   function automatic arp_item_type random_item();
      int r;
      logic [4:0] ch;
      logic [6:0] nn;
      logic [6:0] val;
      r = $urandom_range(0, 99);
      ch = $urandom_range(0, 9) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 2));
      case ($urandom_range(0, 5))
         0: nn = 0;
         1: nn = 127;
         default: nn = 7'($urandom_range(48, 60));
      endcase
      val = $urandom_range(0, 9) == 0 ? 7'd0 : 7'($urandom_range(1, 127));
      if (r < 58) return make_item(OP_TICK, ch, nn, val);
      if (r < 78) return make_item(OP_NOTE_ON, ch, nn, val);
      if (r < 90) return make_item(OP_NOTE_OFF, ch, nn, val);
      if (r < 95) return make_item(OP_SUSTAIN, ch, nn, 7'($urandom_range(0, 127)));
      if (r < 97) return make_item(OP_ALL_OFF, ch, nn, val);
      return make_item(3'($urandom_range(5, 7)), ch, nn, val);
   endfunction

   // Receiver with random stall bursts and, on request, one long hold-off.
   initial begin
      int hold_cnt;
      int stall_cnt;
      bit nr;
      hold_cnt = 0;
      stall_cnt = 0;
      rsp_tready <= 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tuser, rsp_tdata, rsp_tlast);
         if (hold_cnt > 0) begin
            hold_cnt--; nr = 0;
         end else if (long_hold_req) begin
            long_hold_req = 0; hold_cnt = 700; nr = 0;
         end else if (stall_cnt > 0) begin
            stall_cnt--; nr = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(1, 14) - 1; nr = 0;
         end else nr = 1;
         rsp_tready <= nr;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d events outstanding", sb.expected_events.size());
            $display("tb_note_arpeggiator: FAIL");
            $finish;
         end
      end
   end

   initial begin
      arp_item_type it;
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= 0;
      req_tuser <= 0;
      csr_wr_en <= 0;
      csr_addr <= 0;
      csr_wdata <= 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: every step lands on a boundary with the shortest period.
      write_regs({2'b00, PICK_UP}, 1, 16, 16, 256, 2, 0);
      send(make_item(OP_NOTE_ON, 1, 60, 100));
      send(make_item(OP_NOTE_ON, 1, 64, 0));
      send(make_item(OP_NOTE_ON, 16, 127, 127));
      send(make_item(OP_NOTE_ON, 1, 0, 1));
      repeat (3) send(make_item(OP_TICK, 1, 0, 0));
      send(make_item(OP_SUSTAIN, 1, 0, 127));
      send(make_item(OP_NOTE_OFF, 1, 60, 0));
      send(make_item(OP_TICK, 1, 0, 0));
      send(make_item(OP_SUSTAIN, 1, 0, 0));
      send(make_item(3'd5, 1, 0, 0));
      send(make_item(3'd7, 31, 127, 127));
      for (int n = 0; n < 9; n++) send(make_item(OP_NOTE_ON, 2, 7'(10 + n), 7'(64 + n)));
      send(make_item(OP_TICK, 1, 0, 0));
      send(make_item(OP_ALL_OFF, 1, 0, 0));
      send(make_item(OP_TICK, 1, 0, 0));

      for (int ph = 0; ph < 8; ph++) begin
         req_tvalid <= 0;
         wait_drained();
         repeat (SETTLE) @(posedge clock);
         case (ph)
            0: write_regs({2'b00, PICK_DOWN}, 1, 16, 16, 256, 3, 0);
            1: write_regs({2'b01, PICK_UPDOWN}, 4, 3, 8, 300, 0, 32'h4000_4000);
            2: write_regs({2'b10, PICK_CONVERGE}, 7, 31, 0, 0, 24'hFF_FFFF, 32'hFFFF_0000);
            3: write_regs({2'b11, PICK_DIVERGE}, 0, 0, 31, 32'hFFFF_FFFF, 5, 32'hFFFF_FFFF);
            default:
               write_regs({2'($urandom_range(0, 3)), 3'(ph - 1)}, 3'($urandom_range(0, 7)),
                          5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                          $urandom_range(256, 700), 24'($urandom_range(0, 12)),
                          {16'($urandom_range(0, 20000)), 16'($urandom_range(0, 12000))});
         endcase
         if (ph == 7) quiet = 1;
         if (ph == 5) long_hold_req = 1;
         for (int n = 0; n < 25; n++) begin
            if (ph == 6 && n == 12) begin
               req_tvalid <= 0;
               wait_drained();
            end
            send(random_item());
         end
      end
      // One last chord pass so the chord mode and the extremes meet a full pool.
      req_tvalid <= 0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      write_regs({2'b00, PICK_CHORD}, 4, 16, 16, 256, 1, 0);
      for (int n = 0; n < 8; n++) send(make_item(OP_NOTE_ON, 3, 7'(40 + 3 * n), 90));
      for (int n = 0; n < 6; n++) send(make_item(OP_TICK, 3, 0, 0));
      req_tvalid <= 0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (sb.expected_events.size() != 0)
         sb.report($sformatf("%0d events never arrived", sb.expected_events.size()));
      if (sb.errors == 0) begin
         $display("tb_note_arpeggiator: PASS");
      end else begin
         $display("tb_note_arpeggiator: FAIL");
      end
      $finish;
   end
endmodule
